// File: rtl/swirl_warp_address_generator_core_assert.svh
// Assertion macros for the checker file of the swirl warp block.
`ifndef SWIRL_WARP_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define SWIRL_WARP_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWAG_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWAG_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/swag_pkg.sv
package swag_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIM_BITS      = 13;
  localparam int TWIST_BITS    = 16;

  // Register indices on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_TWIST_RATE   = 2'd2
  } cfg_idx_e;

  // Reset values of the registers.
  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [TWIST_BITS-1:0] TWIST_RESET  = 16'd6554;

  // Angle constants in Q.24 and the CORDIC gain compensation in Q.24.
  localparam longint HALF_PI_Q24 = 64'sd26353589;
  localparam longint TWO_PI_Q24  = 4 * HALF_PI_Q24;
  localparam int     GAIN_BITS   = 25;
  localparam logic signed [GAIN_BITS-1:0] GAIN_Q24 = 25'sd10188014;

  // Quarter turn selected ahead of the CORDIC rotation.
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  // Arctangent of 2^-i in Q.24.
  function automatic logic [24:0] atan_q24(input int idx);
    logic [24:0] v;
    case (idx)
      0:       v = 25'd13176795;
      1:       v = 25'd7778716;
      2:       v = 25'd4110060;
      3:       v = 25'd2086331;
      4:       v = 25'd1047214;
      5:       v = 25'd524117;
      6:       v = 25'd262123;
      7:       v = 25'd131069;
      8:       v = 25'd65536;
      9:       v = 25'd32768;
      10:      v = 25'd16384;
      11:      v = 25'd8192;
      12:      v = 25'd4096;
      13:      v = 25'd2048;
      14:      v = 25'd1024;
      15:      v = 25'd512;
      16:      v = 25'd256;
      17:      v = 25'd128;
      18:      v = 25'd64;
      19:      v = 25'd32;
      20:      v = 25'd16;
      21:      v = 25'd8;
      22:      v = 25'd4;
      23:      v = 25'd2;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/swirl_warp_address_generator_core.sv
// Swirl warp address generator.
// An output pixel coordinate enters on the input channel (in_valid_i, in_stall_o,
// out_x_i, out_y_i); the source coordinate to sample leaves on the output channel
// (out_valid_o, out_stall_i, src_x_o, src_y_o, inside_res_o). A transaction is
// accepted at a rising edge where valid is high and stall is low.
// Every coordinate gives exactly one result, in order. When the source lies
// outside the image, inside_res_o is low and both source fields are zero.
// Throughput is one transaction per cycle while no result is held by out_stall_i.
// The pipeline has max(COORD_BITS, 12) + 9 square-root stages and
// min(CORDIC_STAGES, 24) rotation stages.
// The whole pipeline advances together; it holds only while a result is waiting
// and out_stall_i is high, and in that case in_stall_o is raised as well.
// Reset clears every valid bit and loads the register defaults (640 x 480, twist
// rate 6554). Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i
// and are to be changed only while no transaction is in flight.
module swirl_warp_address_generator_core #(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swag_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [swag_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [COORD_BITS-1:0]               out_x_i,
  input  logic [COORD_BITS-1:0]               out_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [COORD_BITS-1:0]               src_x_o,
  output logic [COORD_BITS-1:0]               src_y_o,
  output logic                                inside_res_o
);
  import swag_pkg::*;

  localparam int M    = (COORD_BITS > DIM_BITS - 1) ? COORD_BITS : DIM_BITS - 1;
  localparam int DW   = M + 1;
  localparam int SQW  = 2 * M + 1;
  localparam int NW   = 2 * M + 18;
  localparam int RW   = NW / 2;
  localparam int RMW  = RW + 2;
  localparam int AW   = RW + TWIST_BITS;
  localparam int NMOD = AW - 26;
  localparam int NF   = NMOD + 2;
  localparam int NC   = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int XW   = M + 19;
  localparam int XHW  = XW - 16;
  localparam int ZW   = 28;
  localparam int PLW  = 17 + GAIN_BITS;
  localparam int PHW  = XHW + GAIN_BITS;
  localparam int PW   = XW + 26;
  localparam int SXW  = M + 4;
  localparam logic [COORD_BITS-1:0] CMASK = '1;

  // Configuration registers.
  logic [DIM_BITS-1:0]   width_q, height_q;
  logic [TWIST_BITS-1:0] twist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      twist_q  <= TWIST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[DIM_BITS-1:0];
        CFG_TWIST_RATE:   twist_q  <= cfg_data_i[TWIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Centre of the image.
  logic [M-1:0] cx_m, cy_m;
  assign cx_m = M'(width_q[DIM_BITS-1:1]);
  assign cy_m = M'(height_q[DIM_BITS-1:1]);

  // The pipeline moves as one unless a finished result is held by the receiver.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Offset from the centre.
  logic a_v_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q <= $signed({1'b0, M'(out_x_i)}) - $signed({1'b0, cx_m});
      a_dy_q <= $signed({1'b0, M'(out_y_i)}) - $signed({1'b0, cy_m});
    end
  end

  // Squares of the offsets.
  logic b_v_q;
  logic signed [2*DW-1:0] a_sqx, a_sqy;
  logic [2*M-1:0] b_sqx_q, b_sqy_q;
  logic signed [DW-1:0] b_dx_q, b_dy_q;

  assign a_sqx = a_dx_q * a_dx_q;
  assign a_sqy = a_dy_q * a_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sqx_q <= a_sqx[2*M-1:0];
      b_sqy_q <= a_sqy[2*M-1:0];
      b_dx_q  <= a_dx_q;
      b_dy_q  <= a_dy_q;
    end
  end

  // Squared distance.
  logic c_v_q;
  logic [SQW-1:0] c_sq_q;
  logic signed [DW-1:0] c_dx_q, c_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sq_q <= SQW'(b_sqx_q) + SQW'(b_sqy_q);
      c_dx_q <= b_dx_q;
      c_dy_q <= b_dy_q;
    end
  end

  // Square root of the distance in Q.8, one result bit per stage.
  logic                 s_v  [RW+1];
  logic [RW-1:0]        s_rt [RW+1];
  logic [RMW-1:0]       s_rm [RW+1];
  logic [NW-1:0]        s_n  [RW+1];
  logic signed [DW-1:0] s_dx [RW+1];
  logic signed [DW-1:0] s_dy [RW+1];

  assign s_v[0]  = c_v_q;
  assign s_rt[0] = '0;
  assign s_rm[0] = '0;
  assign s_n[0]  = NW'({c_sq_q, 16'h0000});
  assign s_dx[0] = c_dx_q;
  assign s_dy[0] = c_dy_q;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RMW-1:0] rm_sh, trial;
    logic fits;

    assign rm_sh = {s_rm[i][RMW-3:0], s_n[i][NW-1-2*i -: 2]};
    assign trial = {s_rt[i], 2'b01};
    assign fits  = rm_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v[i+1] <= 1'b0;
      end else if (en) begin
        s_v[i+1] <= s_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_rt[i+1] <= {s_rt[i][RW-2:0], fits};
        s_rm[i+1] <= fits ? rm_sh - trial : rm_sh;
        s_n[i+1]  <= s_n[i];
        s_dx[i+1] <= s_dx[i];
        s_dy[i+1] <= s_dy[i];
      end
    end
  end

  // Twist angle in Q.24.
  logic m_v_q;
  logic [AW-1:0] m_ang_q;
  logic signed [DW-1:0] m_dx_q, m_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= s_v[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ang_q <= s_rt[RW] * twist_q;
      m_dx_q  <= s_dx[RW];
      m_dy_q  <= s_dy[RW];
    end
  end

  // Reduction modulo a full turn by restoring subtraction, then the quarter turn.
  logic                 md_v  [NF+1];
  logic [AW-1:0]        md_a  [NF+1];
  logic [1:0]           md_q  [NF+1];
  logic signed [DW-1:0] md_dx [NF+1];
  logic signed [DW-1:0] md_dy [NF+1];

  assign md_v[0]  = m_v_q;
  assign md_a[0]  = m_ang_q;
  assign md_q[0]  = '0;
  assign md_dx[0] = m_dx_q;
  assign md_dy[0] = m_dy_q;

  for (genvar k = 0; k < NF; k++) begin : g_mod
    localparam int     SHAMT = (k < NMOD) ? NMOD - 1 - k : 0;
    localparam longint SUBL  = (k < NMOD) ? (TWO_PI_Q24 <<< SHAMT) :
                               (k == NMOD) ? 2 * HALF_PI_Q24 : HALF_PI_Q24;
    localparam logic [AW-1:0] SUB  = AW'(SUBL);
    localparam logic [1:0]    QBIT = (k == NMOD) ? 2'b10 : (k == NMOD + 1) ? 2'b01 : 2'b00;
    logic ge;

    assign ge = md_a[k] >= SUB;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        md_v[k+1] <= 1'b0;
      end else if (en) begin
        md_v[k+1] <= md_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        md_a[k+1]  <= ge ? md_a[k] - SUB : md_a[k];
        md_q[k+1]  <= md_q[k] | (ge ? QBIT : 2'b00);
        md_dx[k+1] <= md_dx[k];
        md_dy[k+1] <= md_dy[k];
      end
    end
  end

  // Exact quarter turn of the offset and conversion to Q.16.
  logic signed [DW:0] xr, yr;

  always_comb begin
    case (quad_e'(md_q[NF]))
      QUAD_0: begin
        xr = (DW+1)'(md_dx[NF]);
        yr = (DW+1)'(md_dy[NF]);
      end
      QUAD_90: begin
        xr = -(DW+1)'(md_dy[NF]);
        yr = (DW+1)'(md_dx[NF]);
      end
      QUAD_180: begin
        xr = -(DW+1)'(md_dx[NF]);
        yr = -(DW+1)'(md_dy[NF]);
      end
      default: begin
        xr = (DW+1)'(md_dy[NF]);
        yr = -(DW+1)'(md_dx[NF]);
      end
    endcase
  end

  // CORDIC rotation, one micro-rotation per stage.
  logic                 cr_v [NC+1];
  logic signed [XW-1:0] cr_x [NC+1];
  logic signed [XW-1:0] cr_y [NC+1];
  logic signed [ZW-1:0] cr_z [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_v[0] <= 1'b0;
    end else if (en) begin
      cr_v[0] <= md_v[NF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_x[0] <= {XHW'(xr), 16'h0000};
      cr_y[0] <= {XHW'(yr), 16'h0000};
      cr_z[0] <= ZW'(md_a[NF]);
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] AT = ZW'(atan_q24(i));
    logic signed [XW-1:0] xs, ys;
    logic dir;

    assign xs  = cr_x[i] >>> i;
    assign ys  = cr_y[i] >>> i;
    assign dir = !cr_z[i][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cr_v[i+1] <= 1'b0;
      end else if (en) begin
        cr_v[i+1] <= cr_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cr_x[i+1] <= dir ? cr_x[i] - ys : cr_x[i] + ys;
        cr_y[i+1] <= dir ? cr_y[i] + xs : cr_y[i] - xs;
        cr_z[i+1] <= dir ? cr_z[i] - AT : cr_z[i] + AT;
      end
    end
  end

  // Gain compensation as partial products over the low and high halves.
  logic g1_v_q;
  logic signed [PLW-1:0] g1_xl_q, g1_yl_q;
  logic signed [PHW-1:0] g1_xh_q, g1_yh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
    end else if (en) begin
      g1_v_q <= cr_v[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_xl_q <= $signed({1'b0, cr_x[NC][15:0]}) * GAIN_Q24;
      g1_yl_q <= $signed({1'b0, cr_y[NC][15:0]}) * GAIN_Q24;
      g1_xh_q <= $signed(cr_x[NC][XW-1:16]) * GAIN_Q24;
      g1_yh_q <= $signed(cr_y[NC][XW-1:16]) * GAIN_Q24;
    end
  end

  // Combine the partial products, add the centre back and floor to pixels.
  logic signed [PW-1:0] px, py, sumx, sumy;
  logic g2_v_q;
  logic signed [SXW-1:0] g2_sx_q, g2_sy_q;

  always_comb begin
    px   = (PW'(g1_xh_q) <<< 16) + PW'(g1_xl_q);
    py   = (PW'(g1_yh_q) <<< 16) + PW'(g1_yl_q);
    sumx = (px >>> 24) + $signed(PW'(cx_m) << 16);
    sumy = (py >>> 24) + $signed(PW'(cy_m) << 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2_v_q <= 1'b0;
    end else if (en) begin
      g2_v_q <= g1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_sx_q <= SXW'(sumx >>> 16);
      g2_sy_q <= SXW'(sumy >>> 16);
    end
  end

  // Bounds check and output register.
  logic src_in_img;
  logic [COORD_BITS-1:0] src_x_q, src_y_q;
  logic inside_q;

  assign src_in_img = !g2_sx_q[SXW-1] && !g2_sy_q[SXW-1] &&
                      (g2_sx_q < $signed({1'b0, width_q})) &&
                      (g2_sy_q < $signed({1'b0, height_q})) &&
                      (g2_sx_q <= $signed({1'b0, CMASK})) &&
                      (g2_sy_q <= $signed({1'b0, CMASK}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= g2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_x_q  <= src_in_img ? g2_sx_q[COORD_BITS-1:0] : '0;
      src_y_q  <= src_in_img ? g2_sy_q[COORD_BITS-1:0] : '0;
      inside_q <= src_in_img;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign src_x_o      = src_x_q;
  assign src_y_o      = src_y_q;
  assign inside_res_o = inside_q;

endmodule

// File: rtl/swag_checker.sv
module swag_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] src_x_o,
  input logic [COORD_BITS-1:0] src_y_o,
  input logic                  inside_res_o
);
  `include "swirl_warp_address_generator_core_assert.svh"

  // A held result keeps its payload.
  `SWAG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(src_x_o) && $stable(src_y_o) && $stable(inside_res_o), "stalled result changed")

  // A source outside the image is reported as zero coordinates.
  `SWAG_ASSERT_IMPL(a_black_zero, clk_i, rst_ni, out_valid_o && !inside_res_o, src_x_o == '0 && src_y_o == '0, "outside source with nonzero coordinates")

  // The input is held back only by a waiting, stalled result.
  `SWAG_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")

endmodule

bind swirl_warp_address_generator_core swag_checker #(.COORD_BITS(COORD_BITS)) u_swag_checker (.*);
